/* hdl/bba_pkg.sv */
package bba_pkg;

	// map geometry
	localparam int NUM_BLOCKS    = 4096;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WORD_AW       = $clog2(MAP_WORDS);
	localparam int BIT_W         = $clog2(MAP_WORD_BITS);

	// field widths
	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	// register file
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_ACTIVE_BLOCKS = 1'b0;
	localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(4096);

	// request kinds
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

	// result status
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LOOK,
		S_CHECK,
		S_DONE
	} state_t;

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;

endpackage

/* hdl/bitmap_block_allocator_top.sv */
// First-fit block allocator over a used/free bitmap of NUM_BLOCKS bits, held as MAP_WORDS
// words of MAP_WORD_BITS bits in one internal memory with a single read and a single write
// port. The map reads as all free straight after reset (a valid flag per word stands in for
// a clearing pass), so the block takes items from the first cycle. Only one item is in work
// at a time: in_stall stays high from acceptance until the result item has left the output.
// An allocate streams the map through the word-level search unit one word per cycle from
// word 0, reading words up to the one holding the first free block (at most
// ceil(active/32), 128 for a full map of 4096 blocks). A free or a test is a read, a check
// and a write. An out-of-range index, an unknown command or allocate with an active count
// of zero goes straight to the result. active_blocks sits at byte address 0 and its
// effective value saturates to NUM_BLOCKS; write it only while the block is idle.
module bitmap_block_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bba_pkg::CMD_W-1:0]     cmd,
	input  logic [bba_pkg::IDX_W-1:0]     block_index,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bba_pkg::IDX_W-1:0]     result_index,
	output logic [bba_pkg::STAT_W-1:0]    status,
	output logic                          bit_before,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bba_pkg::PADDR_W-1:0]   paddr,
	input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
	output logic [bba_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import bba_pkg::*;

	// ---------------------------------------------------------------------------
	// register port
	// ---------------------------------------------------------------------------
	logic [CNT_W-1:0] active_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_ACTIVE_BLOCKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			active_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? PDATA_W'(active_q) : '0;

	// effective block count, its last block and the word that holds it
	logic [CNT_W-1:0]   live_n;
	logic [CNT_W-1:0]   last_blk;
	logic [WORD_AW-1:0] last_w;

	assign live_n   = (active_q > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : active_q;
	assign last_blk = live_n - CNT_W'(1);
	assign last_w   = last_blk[BIT_W +: WORD_AW];

	// ---------------------------------------------------------------------------
	// state and request registers
	// ---------------------------------------------------------------------------
	state_t state_q, state_d;

	logic [CMD_W-1:0]   cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WORD_AW-1:0] scan_q;      // next word to read during a search
	logic               scan_end_q;  // every word up to last_w has been read

	logic in_acc;
	logic out_acc;
	logic idx_ok;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign idx_ok  = ({1'b0, block_index} < live_n);

	// ---------------------------------------------------------------------------
	// bitmap memory: valid flag per word so unwritten words read as free
	// ---------------------------------------------------------------------------
	map_word_t          mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] wvld_q;

	logic               rd_en;
	logic [WORD_AW-1:0] rd_addr;
	logic               wr_en;
	map_word_t          wr_data;

	map_word_t          rd_data_s1;
	logic               rd_vld_s1;
	logic               pend_s1;    // read data for addr_s1 arrives this cycle
	logic [WORD_AW-1:0] addr_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			addr_s1    <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q    <= '0;
			rd_vld_s1 <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				wvld_q[addr_s1] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= wvld_q[rd_addr];
			end
			pend_s1 <= rd_en;
		end
	end

	// ---------------------------------------------------------------------------
	// shared word search unit
	// ---------------------------------------------------------------------------
	map_word_t        word_eff;   // word as stored, all free if never written
	map_word_t        elig;       // bits that lie below the active count
	map_word_t        free_v;
	map_word_t        first_free; // lowest free bit, one-hot
	logic             found;
	logic [BIT_W-1:0] found_bit;
	map_word_t        clr_mask;

	assign word_eff = rd_vld_s1 ? rd_data_s1 : '0;

	always_comb begin
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			elig[b] = (addr_s1 != last_w) || (BIT_W'(b) <= last_blk[BIT_W-1:0]);
		end
	end

	assign free_v     = ~word_eff & elig;
	assign first_free = free_v & (~free_v + map_word_t'(1));
	assign found      = |free_v;

	always_comb begin
		found_bit = '0;
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			if (first_free[b]) begin
				found_bit = found_bit | BIT_W'(b);
			end
		end
	end

	assign clr_mask = map_word_t'(1) << idx_q[BIT_W-1:0];

	// ---------------------------------------------------------------------------
	// sequencer: next state
	// ---------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_ALLOC) begin
						state_d = (live_n == '0) ? S_DONE : S_SCAN;
					end else if ((cmd == CMD_FREE || cmd == CMD_TEST) && idx_ok) begin
						state_d = S_LOOK;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (pend_s1 && (found || addr_s1 == last_w)) begin
					state_d = S_DONE;
				end
			end
			S_LOOK:  state_d = S_CHECK;
			S_CHECK: state_d = S_DONE;
			S_DONE: begin
				if (out_acc) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------------
	// sequencer: control outputs
	// ---------------------------------------------------------------------------
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = scan_q;
		wr_en     = 1'b0;
		wr_data   = word_eff | first_free;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_SCAN: begin
				// keep the read stream going until the last word is out
				rd_en = !scan_end_q;
				wr_en = pend_s1 && found;
			end
			S_LOOK: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[BIT_W +: WORD_AW];
			end
			S_CHECK: begin
				// a test writes back the word unchanged
				wr_en   = 1'b1;
				wr_data = (cmd_q == CMD_FREE) ? (word_eff & ~clr_mask) : word_eff;
			end
			S_DONE: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_q     <= '0;
			scan_end_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				scan_q     <= '0;
				scan_end_q <= 1'b0;
			end else if (state_q == S_SCAN && rd_en) begin
				if (scan_q == last_w) begin
					scan_end_q <= 1'b1;
				end else begin
					scan_q <= scan_q + WORD_AW'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// request and result registers
	// ---------------------------------------------------------------------------
	logic [IDX_W-1:0]  res_q;
	logic [STAT_W-1:0] stat_q;
	logic              before_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= cmd;
			idx_q    <= block_index;
			before_q <= 1'b0;
			if (cmd == CMD_ALLOC) begin
				res_q  <= '0;
				stat_q <= STAT_FULL;
			end else begin
				res_q  <= block_index;
				stat_q <= STAT_RANGE;
			end
		end else if (state_q == S_SCAN && pend_s1 && found) begin
			res_q  <= IDX_W'({addr_s1, found_bit});
			stat_q <= STAT_OK;
		end else if (state_q == S_CHECK) begin
			before_q <= word_eff[idx_q[BIT_W-1:0]];
			stat_q   <= STAT_OK;
		end
	end

	assign result_index = res_q;
	assign status       = stat_q;
	assign bit_before   = before_q;

	// ---------------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------------
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("item accepted while another is in work");

	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |=> !in_stall && !out_valid)
		else $error("block not idle after result delivered");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN || state_q == S_CHECK))
		else $error("map write outside search or check");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_q == CMD_ALLOC && status == STAT_OK
		|-> {1'b0, result_index} < live_n)
		else $error("granted block beyond active count");

	a_scan_stops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && pend_s1 && !found && addr_s1 == last_w |=> state_q == S_DONE)
		else $error("search ran past last word");

endmodule

/* dv/tb_bitmap_block_allocator_top.sv */
// expected answer for one request item
typedef struct packed {
	logic [bba_pkg::IDX_W-1:0]  index;
	logic [bba_pkg::STAT_W-1:0] stat;
	logic                       prior;
} grant_t;

// shadow of the used/free map and the active count, plus answers still owed
class alloc_book;
	bit [bba_pkg::NUM_BLOCKS-1:0] used_bits;
	logic [bba_pkg::CNT_W-1:0]    active;
	grant_t                       owed[$];
	int                           errors;

	function new();
		used_bits = '0;
		active    = bba_pkg::ACTIVE_RESET;
		errors    = 0;
	endfunction

	function void set_active(logic [bba_pkg::CNT_W-1:0] value);
		active = value;
	endfunction

	// active count saturated to the map size
	function int live();
		if (int'(active) > bba_pkg::NUM_BLOCKS)
			return bba_pkg::NUM_BLOCKS;
		return int'(active);
	endfunction

	function int pending();
		return owed.size();
	endfunction

	function void note_request(logic [bba_pkg::CMD_W-1:0] kind,
			logic [bba_pkg::IDX_W-1:0] idx);
		grant_t g;
		int     n;
		n        = live();
		g.index  = idx;
		g.stat   = bba_pkg::STAT_RANGE;
		g.prior  = 1'b0;
		if (kind == bba_pkg::CMD_ALLOC) begin
			g.index = '0;
			g.stat  = bba_pkg::STAT_FULL;
			for (int i = 0; i < n; i++) begin
				if (!used_bits[i]) begin
					used_bits[i] = 1'b1;
					g.index      = bba_pkg::IDX_W'(i);
					g.stat       = bba_pkg::STAT_OK;
					break;
				end
			end
		end else if ((kind == bba_pkg::CMD_FREE || kind == bba_pkg::CMD_TEST) &&
				int'(idx) < n) begin
			g.prior = used_bits[idx];
			if (kind == bba_pkg::CMD_FREE)
				used_bits[idx] = 1'b0;
			g.stat = bba_pkg::STAT_OK;
		end
		owed.push_back(g);
	endfunction

	function void check_result(logic [bba_pkg::IDX_W-1:0] idx,
			logic [bba_pkg::STAT_W-1:0] st, logic bb);
		grant_t g;
		if (owed.size() == 0) begin
			$error("result item arrived with nothing outstanding");
			errors++;
			return;
		end
		g = owed.pop_front();
		if (idx !== g.index) begin
			$error("result_index: expected %0d, got %0d", g.index, idx);
			errors++;
		end
		if (st !== g.stat) begin
			$error("status: expected %0d, got %0d", g.stat, st);
			errors++;
		end
		if (bb !== g.prior) begin
			$error("bit_before: expected %0d, got %0d", g.prior, bb);
			errors++;
		end
	endfunction
endclass

module tb_bitmap_block_allocator_top;
	import bba_pkg::*;

	// register addresses: the only register at byte 0, next slot unmapped
	localparam logic [PADDR_W-1:0] ADDR_ACTIVE = PADDR_W'(4 * REG_ACTIVE_BLOCKS);
	localparam logic [PADDR_W-1:0] ADDR_SPARE  = PADDR_W'(4);
	// command code the block does not know
	localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;
	// quiet cycles after the last answer before touching the register
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-off used to back the block up
	localparam int HOLD_CYCLES = 400;
	// overall watchdog, far above a full-scan run with worst idling
	localparam longint LIMIT_TIME = 64'd40_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CMD_W-1:0]     cmd;
	logic [IDX_W-1:0]     block_index;
	logic                 out_valid;
	logic                 out_stall;
	logic [IDX_W-1:0]     result_index;
	logic [STAT_W-1:0]    status;
	logic                 bit_before;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	alloc_book book;
	// percentage that steers how often either side idles; zero means none
	int  idle_pct;
	// set by the stimulus to ask the receiver for one long hold-off
	bit  hold_req;

	bitmap_block_allocator_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.block_index  (block_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_index (result_index),
		.status       (status),
		.bit_before   (bit_before),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	initial begin
		#(LIMIT_TIME);
		$display("FAILURE");
		$finish;
	end

	// offer one request item, with an optional gap first, and wait for it to be taken
	task automatic send_item(logic [CMD_W-1:0] kind, logic [IDX_W-1:0] idx);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= kind;
		block_index <= idx;
		do @(posedge clk); while (in_stall);
		// accepted at this edge: work out what the block owes us
		book.note_request(kind, idx);
	endtask

	// lower valid and wait for the block to fall quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup then access cycle; the write lands on the edge with pready high
	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// writes to the unmapped slot are dropped
		if (addr == ADDR_ACTIVE)
			book.set_active(data[CNT_W-1:0]);
	endtask

	// one random request; mostly in-range indices so frees and tests hit real blocks
	task automatic rand_item(int alloc_pct, int free_pct);
		logic [CMD_W-1:0] kind;
		logic [IDX_W-1:0] idx;
		int               n;
		int               r;
		n = book.live();
		r = $urandom_range(0, 99);
		if (r < 2)
			kind = CMD_BAD;
		else if (r < alloc_pct)
			kind = CMD_ALLOC;
		else if (r < alloc_pct + free_pct)
			kind = CMD_FREE;
		else
			kind = CMD_TEST;
		r = $urandom_range(0, 9);
		if (n == 0 || r < 2)
			idx = IDX_W'($urandom());
		else if (r < 4)
			idx = IDX_W'(n - 1 + $urandom_range(0, 2));  // around the active edge
		else if (r < 6)
			idx = IDX_W'($urandom_range(0, ((n < 64) ? n : 64) - 1));  // dense low region
		else
			idx = IDX_W'($urandom_range(0, n - 1));
		send_item(kind, idx);
	endtask

	task automatic run_phase(int count, int alloc_pct, int free_pct);
		repeat (count) rand_item(alloc_pct, free_pct);
	endtask

	// result side: check every taken item, stall in bursts, and serve a long hold-off
	initial begin : sink
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				book.check_result(result_index, status, bit_before);
			if (hold > 0) begin
				hold--;
				if (hold == 0)
					out_stall <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold     = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
				hold = $urandom_range(1, 17);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		book     = new();
		idle_pct = 25;
		hold_req = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cmd         <= CMD_ALLOC;
		block_index <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fresh map, full 4096 blocks
		send_item(CMD_TEST, 12'd0);        // cleared map reads free
		send_item(CMD_ALLOC, 12'hFFF);     // index ignored on allocate
		send_item(CMD_ALLOC, 12'd0);
		send_item(CMD_TEST, 12'd1);
		send_item(CMD_FREE, 12'd1);
		send_item(CMD_FREE, 12'd1);        // freeing a free block still succeeds
		send_item(CMD_ALLOC, 12'd0);       // first fit refills the hole
		send_item(CMD_TEST, 12'hFFF);      // top of the map
		send_item(CMD_FREE, 12'hFFF);
		send_item(CMD_BAD, 12'hABC);       // unknown command echoes the index
		send_item(CMD_BAD, 12'd0);

		// tiny active count: run out of blocks, reject indices past the end
		settle();
		write_reg(ADDR_ACTIVE, 32'd3);
		send_item(CMD_ALLOC, 12'd0);
		send_item(CMD_ALLOC, 12'd0);       // nothing free below three
		send_item(CMD_TEST, 12'd3);
		send_item(CMD_FREE, 12'hFFF);
		send_item(CMD_FREE, 12'd0);
		send_item(CMD_ALLOC, 12'd0);

		// zero active blocks: everything full or out of range
		settle();
		write_reg(ADDR_ACTIVE, 32'd0);
		send_item(CMD_ALLOC, 12'd0);
		send_item(CMD_TEST, 12'd0);
		send_item(CMD_FREE, 12'd0);

		// unmapped register slot must leave the count alone
		settle();
		write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
		send_item(CMD_TEST, 12'd2);

		// all-ones count saturates to the map size
		settle();
		write_reg(ADDR_ACTIVE, 32'h0000_1FFF);
		send_item(CMD_TEST, 12'hFFF);
		send_item(CMD_ALLOC, 12'd0);
		send_item(CMD_TEST, 12'h800);

		// small pool, allocate and free churn with frequent full answers
		settle();
		write_reg(ADDR_ACTIVE, 32'd40);
		run_phase(400, 55, 25);

		// saturated count, mostly allocates so the scan walks many words;
		// the receiver backs off for a long stretch at the start
		settle();
		write_reg(ADDR_ACTIVE, 32'h0000_1FFF);
		idle_pct = 10;
		hold_req = 1'b1;
		run_phase(450, 80, 10);

		// zero and one active blocks
		settle();
		write_reg(ADDR_ACTIVE, 32'd0);
		idle_pct = 30;
		run_phase(20, 40, 30);
		settle();
		write_reg(ADDR_ACTIVE, 32'd1);
		run_phase(60, 45, 30);

		// a few random counts across the range
		repeat (3) begin
			settle();
			write_reg(ADDR_ACTIVE, PDATA_W'($urandom_range(1, NUM_BLOCKS)));
			run_phase(100, 50, 25);
		end

		// closing stretch at the full count with no idling on either side
		settle();
		write_reg(ADDR_ACTIVE, PDATA_W'(NUM_BLOCKS));
		idle_pct = 0;
		run_phase(400, 50, 25);

		settle();
		if (book.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
